@@ src/sktu_pkg.sv @@
// ----------------------------------------------------------------------------
// sktu_pkg
// Shared types and constants of the sorted key table.
// ----------------------------------------------------------------------------
package sktu_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int DEF_KEY_BITS = 32;

    localparam int KEY_W  = 32;
    localparam int POS_W  = 5;
    localparam int STAT_W = 3;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_DELETE = 1'b1
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef struct packed {
        logic load_key;
        logic load_left;
        logic load_right;
    } t_cell_ctrl;

endpackage

@@ src/sorted_key_table_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table_unit
// Table of distinct keys in ascending order with insert and delete requests.
// ----------------------------------------------------------------------------
// One request is handled at a time. Every slot compares its key with the
// request key; a binary search over those flags then resolves one halving per
// cycle, and a final step shifts the slots and posts the result once the
// result register is free. With n keys held the search takes at most
// ceil(log2(n + 1)) halving steps. The result register lets the next request
// be accepted while a finished result is still waiting to be taken.
module sorted_key_table_unit import sktu_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    input  logic [KEY_W-1:0]  i_key,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [POS_W-1:0]  o_position,
    output logic [POS_W-1:0]  o_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SEARCH,
        S_APPLY
    } t_state;

    t_state                r_state;
    logic                  r_func;
    logic [KEY_BITS-1:0]   r_key;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_lo;
    logic [CW-1:0]         r_hi;
    logic                  r_cmp_signed;
    logic                  r_out_valid;
    t_status               r_status;
    logic [POS_W-1:0]      r_position;
    logic [POS_W-1:0]      r_out_count;

    logic [KEY_BITS+KEY_W-1:0] w_key_ext;
    logic [KEY_BITS-1:0]       w_key_in;
    logic [KEY_BITS-1:0]       w_cell_key [CAPACITY];
    logic [CAPACITY-1:0]       w_gt;
    logic [CAPACITY-1:0]       w_eq;
    t_cell_ctrl                w_ctrl [CAPACITY];
    logic [CW:0]               w_sum;
    logic [CW-1:0]             w_mid;
    logic                      w_hit;
    logic                      w_fire;
    logic                      w_do_ins;
    logic                      w_do_del;
    t_status                   w_status;
    logic [CW-1:0]             w_new_count;
    logic [CW+POS_W-1:0]       w_pos_ext;
    logic [CW+POS_W-1:0]       w_cnt_ext;

    assign w_key_ext = {{KEY_BITS{1'b0}}, i_key};
    assign w_key_in  = w_key_ext[KEY_BITS-1:0];

    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_sum[CW:1];
    assign w_hit = (r_lo < r_count) && w_eq[r_lo[IW-1:0]];

    assign w_fire = (r_state == S_APPLY) && (!r_out_valid || i_out_ready);

    always_comb begin
        w_status    = ST_OK;
        w_do_ins    = 1'b0;
        w_do_del    = 1'b0;
        w_new_count = r_count;
        if (r_func == FUNC_INSERT) begin
            if (w_hit) begin
                w_status = ST_DUP;
            end else if (r_count == CW'(CAPACITY)) begin
                w_status = ST_FULL;
            end else begin
                w_do_ins    = w_fire;
                w_new_count = r_count + 1'b1;
            end
        end else begin
            if (r_count == '0) begin
                w_status = ST_EMPTY;
            end else if (!w_hit) begin
                w_status = ST_NOTFOUND;
            end else begin
                w_do_del    = w_fire;
                w_new_count = r_count - 1'b1;
            end
        end
    end

    assign w_pos_ext = {{POS_W{1'b0}}, r_lo};
    assign w_cnt_ext = {{POS_W{1'b0}}, w_new_count};

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KEY_BITS-1:0] w_left;
        logic [KEY_BITS-1:0] w_right;

        if (i == 0) begin : g_first
            assign w_left = w_cell_key[i];
        end else begin : g_inner_l
            assign w_left = w_cell_key[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = w_cell_key[i];
        end else begin : g_inner_r
            assign w_right = w_cell_key[i+1];
        end

        assign w_ctrl[i].load_key   = w_do_ins && (CW'(i) == r_lo);
        assign w_ctrl[i].load_left  = w_do_ins && (CW'(i) > r_lo) && (CW'(i) <= r_count);
        assign w_ctrl[i].load_right = w_do_del && (CW'(i) >= r_lo) && (CW'(i + 1) < r_count);

        sktu_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_cap    (r_state == S_CMP),
            .i_signed (r_cmp_signed),
            .i_key    (r_key),
            .i_left   (w_left),
            .i_right  (w_right),
            .i_ctrl   (w_ctrl[i]),
            .o_key    (w_cell_key[i]),
            .o_gt     (w_gt[i]),
            .o_eq     (w_eq[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_cmp_signed <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cmp_signed <= i_cfg_data;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func  <= i_func;
                        r_key   <= w_key_in;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_lo    <= '0;
                    r_hi    <= r_count;
                    r_state <= S_SEARCH;
                end
                S_SEARCH: begin
                    if (r_lo < r_hi) begin
                        if (w_gt[w_mid[IW-1:0]]) begin
                            r_lo <= w_mid + 1'b1;
                        end else begin
                            r_hi <= w_mid;
                        end
                    end else begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (w_fire) begin
                        r_status    <= w_status;
                        r_position  <= w_pos_ext[POS_W-1:0];
                        r_out_count <= w_cnt_ext[POS_W-1:0];
                        r_count     <= w_new_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_position  = r_position;
    assign o_count     = r_out_count;

endmodule

@@ src/sktu_cell.sv @@
// ----------------------------------------------------------------------------
// sktu_cell
// One slot of the table: holds a key, compares it against the request key
// and loads its left neighbor, its right neighbor or the new key.
// ----------------------------------------------------------------------------
module sktu_cell import sktu_pkg::*; #(
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic                i_clk,
    input  logic                i_cap,
    input  logic                i_signed,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [KEY_BITS-1:0] i_left,
    input  logic [KEY_BITS-1:0] i_right,
    input  t_cell_ctrl          i_ctrl,
    output logic [KEY_BITS-1:0] o_key,
    output logic                o_gt,
    output logic                o_eq
);

    logic [KEY_BITS-1:0] r_key;
    logic                r_gt;
    logic                r_eq;
    logic [KEY_BITS-1:0] w_flip;

    assign w_flip = KEY_BITS'(i_signed) << (KEY_BITS - 1);

    always_ff @(posedge i_clk) begin
        if (i_cap) begin
            r_gt <= (i_key ^ w_flip) > (r_key ^ w_flip);
            r_eq <= (i_key == r_key);
        end
        if (i_ctrl.load_key) begin
            r_key <= i_key;
        end else if (i_ctrl.load_left) begin
            r_key <= i_left;
        end else if (i_ctrl.load_right) begin
            r_key <= i_right;
        end
    end

    assign o_key = r_key;
    assign o_gt  = r_gt;
    assign o_eq  = r_eq;

endmodule

@@ src/sktu_checker.sv @@
// ----------------------------------------------------------------------------
// sktu_checker
// Port-level checks of the sorted key table, bound to the top level.
// ----------------------------------------------------------------------------
module sktu_checker import sktu_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [STAT_W-1:0] o_status,
    input logic [POS_W-1:0]  o_position,
    input logic [POS_W-1:0]  o_count
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("block not idle after reset");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> (o_count == '0 && o_position == '0))
        else $error("empty result with nonzero position or count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_count == POS_W'(CAPACITY)))
        else $error("full result without full count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_status) && $stable(o_position) && $stable(o_count)))
        else $error("stalled result changed");

endmodule

bind sorted_key_table_unit sktu_checker #(
    .CAPACITY (CAPACITY)
) u_sktu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_position  (o_position),
    .o_count     (o_count)
);

@@ tb/sorted_key_table_unit_test.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table_unit_test
// Self-checking bench for the sorted key table: a directed table of requests
// covering the edge cases, then random inserts and deletes in phases alternating
// the compare mode, each result checked against the table's value or an in-bench model.
// ----------------------------------------------------------------------------
module sorted_key_table_unit_test;
    import sktu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP          = DEF_CAPACITY;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int POOL_SIZE    = 24;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 145;
    localparam int IDLE_PCT     = 15;

    typedef struct {
        t_status          st;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] cnt;
    } t_result;

    typedef struct {
        t_func            f;
        logic [KEY_W-1:0] k;
        bit               typed;
        t_result          want;
    } t_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_data  = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic              i_func      = 1'b0;
    logic [KEY_W-1:0]  i_key       = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [STAT_W-1:0] o_status;
    logic [POS_W-1:0]  o_position;
    logic [POS_W-1:0]  o_count;

    logic [KEY_W-1:0] held_keys [CAP];
    int               held_count  = 0;
    bit               signed_mode = 1'b0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    t_result          pending_results [$];
    t_row             directed_rows [$];
    int               mismatches  = 0;
    int               cycle_count = 0;
    bit               steady      = 1'b0;

    sorted_key_table_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_position  (o_position),
        .o_count     (o_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] order_of(logic [KEY_W-1:0] k);
        return signed_mode ? (k ^ {1'b1, {(KEY_W-1){1'b0}}}) : k;
    endfunction

    function automatic int lower_bound_of(logic [KEY_W-1:0] k);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = held_count;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (order_of(k) > order_of(held_keys[mid])) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic t_result apply_request(t_func f, logic [KEY_W-1:0] k);
        t_result r;
        int      lb;
        int      i;
        r.st  = ST_OK;
        r.pos = '0;
        if (f == FUNC_INSERT) begin
            lb    = lower_bound_of(k);
            r.pos = lb[POS_W-1:0];
            if (lb < held_count && held_keys[lb] == k) begin
                r.st = ST_DUP;
            end else if (held_count >= CAP) begin
                r.st = ST_FULL;
            end else begin
                for (i = held_count; i > lb; i--) begin
                    held_keys[i] = held_keys[i-1];
                end
                held_keys[lb] = k;
                held_count++;
            end
        end else if (held_count == 0) begin
            r.st = ST_EMPTY;
        end else begin
            lb    = lower_bound_of(k);
            r.pos = lb[POS_W-1:0];
            if (lb >= held_count || held_keys[lb] != k) begin
                r.st = ST_NOTFOUND;
            end else begin
                for (i = lb; i + 1 < held_count; i++) begin
                    held_keys[i] = held_keys[i+1];
                end
                held_count--;
            end
        end
        r.cnt = held_count[POS_W-1:0];
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(t_func f);
        if (f == FUNC_DELETE && held_count > 0 && $urandom_range(0, 99) < 60) begin
            return held_keys[$urandom_range(0, held_count - 1)];
        end
        if ($urandom_range(0, 99) < 70) begin
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: mismatch, %s", $time, what);
    endtask

    task automatic add_row(input t_func f, input logic [KEY_W-1:0] k, input bit typed,
                           input t_status st, input int pos, input int cnt);
        t_row row;
        row.f        = f;
        row.k        = k;
        row.typed    = typed;
        row.want.st  = st;
        row.want.pos = pos[POS_W-1:0];
        row.want.cnt = cnt[POS_W-1:0];
        directed_rows.push_back(row);
    endtask

    // The valid stays high after acceptance; it is only lowered for a gap, before
    // a register write or at the end, so it never drops and rises in one step.
    task automatic send_request(input t_func f, input logic [KEY_W-1:0] k, input bit typed,
                                input t_result want);
        int      gap;
        t_result model_res;
        gap = 0;
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_key      <= k;
        do @(posedge i_clk); while (!o_in_ready);
        model_res = apply_request(f, k);
        pending_results.push_back(typed ? want : model_res);
    endtask

    task automatic write_compare_mode(input bit v);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        signed_mode = v;
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with none expected (status %0d)", o_status));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.st) begin
                    report_mismatch($sformatf("status %0d, expected %0d", o_status, want.st));
                end
                if (o_position !== want.pos) begin
                    report_mismatch($sformatf("position %0d, expected %0d",
                                              o_position, want.pos));
                end
                if (o_count !== want.cnt) begin
                    report_mismatch($sformatf("count %0d, expected %0d", o_count, want.cnt));
                end
            end
        end
    end

    initial begin
        t_result none;
        t_func   f;
        int      ins_pct;
        int      phase;
        int      n;
        none.st  = ST_OK;
        none.pos = '0;
        none.cnt = '0;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'h0000_0001;
        key_pool[2] = 32'h7FFF_FFFF;
        key_pool[3] = 32'h8000_0000;
        key_pool[4] = 32'hFFFF_FFFE;
        key_pool[5] = 32'hFFFF_FFFF;
        for (n = 6; n < POOL_SIZE; n++) key_pool[n] = $urandom;

        add_row(FUNC_DELETE, 32'h0000_0005, 1, ST_EMPTY, 0, 0);
        add_row(FUNC_INSERT, 32'h0000_0000, 1, ST_OK,    0, 1);
        add_row(FUNC_INSERT, 32'hFFFF_FFFF, 1, ST_OK,    1, 2);
        add_row(FUNC_INSERT, 32'h0000_0000, 1, ST_DUP,   0, 2);
        add_row(FUNC_INSERT, 32'h8000_0000, 1, ST_OK,    1, 3);
        add_row(FUNC_DELETE, 32'h0000_0007, 0, ST_OK,    0, 0);
        add_row(FUNC_INSERT, 32'h7FFF_FFFF, 0, ST_OK,    0, 0);
        for (n = 1; n <= 12; n++) begin
            add_row(FUNC_INSERT, 32'h0001_0000 * n + 32'h0000_0A5A, 0, ST_OK, 0, 0);
        end
        add_row(FUNC_INSERT, 32'h5555_5555, 0, ST_OK, 0, 0);
        add_row(FUNC_INSERT, 32'h8000_0000, 0, ST_OK, 0, 0);
        add_row(FUNC_DELETE, 32'hFFFF_FFFE, 0, ST_OK, 0, 0);
        add_row(FUNC_DELETE, 32'hFFFF_FFFF, 0, ST_OK, 0, 0);
        add_row(FUNC_DELETE, 32'hFFFF_FFFF, 0, ST_OK, 0, 0);
        add_row(FUNC_DELETE, 32'h0000_0000, 0, ST_OK, 0, 0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_request(directed_rows[r].f, directed_rows[r].k, directed_rows[r].typed,
                         directed_rows[r].want);
        end

        // The table is kept across mode changes, so stale orderings get searched too.
        for (phase = 0; phase < PHASES; phase++) begin
            write_compare_mode(phase % 2 == 0);
            steady  = (phase == 4);
            ins_pct = (phase % 3 == 2) ? 25 : 70;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                f = ($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_DELETE;
                send_request(f, pick_key(f), 0, none);
            end
        end
        steady = 1'b0;

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sorted_key_table_unit.f @@
src/sktu_pkg.sv
src/sktu_cell.sv
src/sorted_key_table_unit.sv
src/sktu_checker.sv
tb/sorted_key_table_unit_test.sv
